// ----- sv/asc_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants for the arc set comparator: input codes,
// result kinds, the controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int VERTEX_W = 32;
    localparam int KEY_W    = 64;
    localparam int FUNC_W   = 2;
    localparam int KIND_W   = 3;

    localparam logic [VERTEX_W-1:0] CNT_MAX = '1;

    localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CHECK  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FINISH = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_MATCHED          = 3'd0,
        KIND_DUPLICATE        = 3'd1,
        KIND_UNMATCHED_STREAM = 3'd2,
        KIND_UNMATCHED_TABLE  = 3'd3,
        KIND_DONE             = 3'd4,
        KIND_TABLE_FULL       = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_SRCH_STEP,
        OP_LOAD,
        OP_EMIT,
        OP_SW_NEXT,
        OP_SW_TAKE,
        OP_SW_END
    } op_t;

    typedef struct packed {
        op_t   op;
        kind_t kind;
        logic  rd_sweep;
    } asc_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic lo_lt_hi;
        logic key_eq;
        logic mark_hit;
        logic sw_done;
        logic sw_unmarked;
        logic pend_valid;
        logic out_free;
    } asc_stat_t;

    function automatic logic [VERTEX_W-1:0] sat_inc(input logic [VERTEX_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + VERTEX_W'(1);
    endfunction

endpackage

// ----- sv/asc_ram.sv -----
// ----------------------------------------------------------------------------
// asc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module asc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/asc_dpath.sv -----
// ----------------------------------------------------------------------------
// asc_dpath
// Datapath of the arc set comparator: key table and match mark RAMs, search
// bounds, sweep index, saturating counters, pending sweep result and the
// output register.
// ----------------------------------------------------------------------------
module asc_dpath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  asc_pkg::asc_cmd_t                 cmd,
    output asc_pkg::asc_stat_t                stat,
    input  logic [asc_pkg::VERTEX_W-1:0]      s_src,
    input  logic [asc_pkg::VERTEX_W-1:0]      s_dst,
    input  logic                              m_ready,
    output logic                              m_valid,
    output asc_pkg::kind_t                    m_kind,
    output logic [asc_pkg::VERTEX_W-1:0]      m_src,
    output logic [asc_pkg::VERTEX_W-1:0]      m_dst,
    output logic [asc_pkg::VERTEX_W-1:0]      m_mis,
    output logic [asc_pkg::VERTEX_W-1:0]      m_dup,
    output logic                              m_last
);

    import asc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0]       key_reg, key_next;
    logic [IDX_W-1:0]       lo_reg, lo_next;
    logic [IDX_W-1:0]       hi_reg, hi_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VERTEX_W-1:0]    mis_reg, mis_next;
    logic [VERTEX_W-1:0]    dup_reg, dup_next;
    logic [KEY_W-1:0]       pend_key_reg, pend_key_next;
    logic [VERTEX_W-1:0]    pend_mis_reg, pend_mis_next;
    logic                   pend_valid_reg, pend_valid_next;

    logic                   m_valid_reg, m_valid_next;
    kind_t                  m_kind_reg, m_kind_next;
    logic [KEY_W-1:0]       m_key_reg, m_key_next;
    logic [VERTEX_W-1:0]    m_mis_reg, m_mis_next;
    logic [VERTEX_W-1:0]    m_dup_reg, m_dup_next;
    logic                   m_last_reg, m_last_next;

    logic [IDX_W:0]         mid_sum;
    logic [IDX_W-1:0]       mid;
    logic [CNT_W-1:0]       count_m1;
    logic [IDX_W-1:0]       raddr;
    logic [KEY_W-1:0]       rdata;
    logic                   ram_we;
    logic                   mark_we;
    logic [IDX_W-1:0]       mark_waddr;
    logic                   mark_wdata;
    logic                   mark_rd;
    logic                   out_load;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IDX_W:1];
    assign count_m1 = count_reg - CNT_W'(1);
    assign raddr    = cmd.rd_sweep ? idx_reg[IDX_W-1:0] : mid;

    asc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    asc_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_marks (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (raddr),
        .rdata (mark_rd)
    );

    always_comb begin
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        mis_next        = mis_reg;
        dup_next        = dup_reg;
        pend_key_next   = pend_key_reg;
        pend_mis_next   = pend_mis_reg;
        pend_valid_next = pend_valid_reg;
        m_kind_next     = m_kind_reg;
        m_key_next      = m_key_reg;
        m_mis_next      = m_mis_reg;
        m_dup_next      = m_dup_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        mark_we         = 1'b0;
        mark_waddr      = count_reg[IDX_W-1:0];
        mark_wdata      = 1'b0;
        out_load        = 1'b0;

        case (cmd.op)
            OP_LATCH: begin
                key_next        = {s_src, s_dst};
                lo_next         = '0;
                hi_next         = count_m1[IDX_W-1:0];
                idx_next        = '0;
                pend_valid_next = 1'b0;
            end
            OP_SRCH_STEP: begin
                if (rdata < key_reg) begin
                    lo_next = mid + IDX_W'(1);
                end else begin
                    hi_next = mid;
                end
            end
            OP_LOAD: begin
                ram_we     = 1'b1;
                mark_we    = 1'b1;
                mark_waddr = count_reg[IDX_W-1:0];
                mark_wdata = 1'b0;
                count_next = count_reg + CNT_W'(1);
            end
            OP_EMIT: begin
                case (cmd.kind)
                    KIND_UNMATCHED_STREAM: mis_next = sat_inc(mis_reg);
                    KIND_DUPLICATE:        dup_next = sat_inc(dup_reg);
                    KIND_MATCHED: begin
                        mark_we    = 1'b1;
                        mark_waddr = mid;
                        mark_wdata = 1'b1;
                    end
                    default: ;
                endcase
                out_load    = 1'b1;
                m_kind_next = cmd.kind;
                m_key_next  = key_reg;
                m_mis_next  = mis_next;
                m_dup_next  = dup_next;
                m_last_next = 1'b1;
            end
            OP_SW_NEXT: begin
                idx_next = idx_reg + CNT_W'(1);
            end
            OP_SW_TAKE: begin
                if (pend_valid_reg) begin
                    out_load    = 1'b1;
                    m_kind_next = KIND_UNMATCHED_TABLE;
                    m_key_next  = pend_key_reg;
                    m_mis_next  = pend_mis_reg;
                    m_dup_next  = dup_reg;
                    m_last_next = 1'b0;
                end
                mis_next        = sat_inc(mis_reg);
                pend_key_next   = rdata;
                pend_mis_next   = sat_inc(mis_reg);
                pend_valid_next = 1'b1;
                idx_next        = idx_reg + CNT_W'(1);
            end
            OP_SW_END: begin
                out_load    = 1'b1;
                m_last_next = 1'b1;
                m_dup_next  = dup_reg;
                if (pend_valid_reg) begin
                    m_kind_next = KIND_UNMATCHED_TABLE;
                    m_key_next  = pend_key_reg;
                    m_mis_next  = pend_mis_reg;
                end else begin
                    m_kind_next = KIND_DONE;
                    m_key_next  = '0;
                    m_mis_next  = mis_reg;
                end
                count_next      = '0;
                mis_next        = '0;
                dup_next        = '0;
                pend_valid_next = 1'b0;
            end
            default: ;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            mis_reg        <= '0;
            dup_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            mis_reg        <= mis_next;
            dup_reg        <= dup_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        pend_key_reg <= pend_key_next;
        pend_mis_reg <= pend_mis_next;
        m_kind_reg   <= m_kind_next;
        m_key_reg    <= m_key_next;
        m_mis_reg    <= m_mis_next;
        m_dup_reg    <= m_dup_next;
        m_last_reg   <= m_last_next;
    end

    assign stat.cnt_zero    = (count_reg == '0);
    assign stat.cnt_full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.lo_lt_hi    = (lo_reg < hi_reg);
    assign stat.key_eq      = (rdata == key_reg);
    assign stat.mark_hit    = mark_rd;
    assign stat.sw_done     = (idx_reg == count_reg);
    assign stat.sw_unmarked = !mark_rd;
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_src   = m_key_reg[KEY_W-1:VERTEX_W];
    assign m_dst   = m_key_reg[VERTEX_W-1:0];
    assign m_mis   = m_mis_reg;
    assign m_dup   = m_dup_reg;
    assign m_last  = m_last_reg;

endmodule

// ----- sv/asc_ctrl.sv -----
// ----------------------------------------------------------------------------
// asc_ctrl
// Controller of the arc set comparator: decodes each input item and
// sequences table loads, the binary search probes and the finish sweep.
// ----------------------------------------------------------------------------
module asc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [asc_pkg::FUNC_W-1:0]   s_func,
    output logic                         s_ready,
    input  asc_pkg::asc_stat_t           stat,
    output asc_pkg::asc_cmd_t            cmd
);

    import asc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FULL,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RESULT,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_END
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.kind     = KIND_MATCHED;
        cmd.rd_sweep = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LATCH;
                    unique case (s_func)
                        FN_LOAD:   state_next = stat.cnt_full ? ST_FULL : ST_LOAD;
                        FN_CHECK:  state_next = stat.cnt_zero ? ST_RESULT : ST_SRCH_RD;
                        FN_FINISH: state_next = ST_SW_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.op     = OP_LOAD;
                state_next = ST_IDLE;
            end
            ST_FULL: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    cmd.kind   = KIND_TABLE_FULL;
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (stat.lo_lt_hi) begin
                    cmd.op     = OP_SRCH_STEP;
                    state_next = ST_SRCH_RD;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.op = OP_EMIT;
                    if (stat.cnt_zero || !stat.key_eq) begin
                        cmd.kind = KIND_UNMATCHED_STREAM;
                    end else if (stat.mark_hit) begin
                        cmd.kind = KIND_DUPLICATE;
                    end else begin
                        cmd.kind = KIND_MATCHED;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SW_RD: begin
                cmd.rd_sweep = 1'b1;
                if (stat.sw_done) begin
                    state_next = ST_SW_END;
                end else begin
                    state_next = ST_SW_CHK;
                end
            end
            ST_SW_CHK: begin
                cmd.rd_sweep = 1'b1;
                if (!stat.sw_unmarked) begin
                    cmd.op     = OP_SW_NEXT;
                    state_next = ST_SW_RD;
                end else if (!stat.pend_valid || stat.out_free) begin
                    cmd.op     = OP_SW_TAKE;
                    state_next = ST_SW_RD;
                end
            end
            ST_SW_END: begin
                if (stat.out_free) begin
                    cmd.op     = OP_SW_END;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ----- sv/arc_set_compare.sv -----
// ----------------------------------------------------------------------------
// arc_set_compare
// Compares a stream of directed arcs against a sorted table of arcs.
//
// The slave channel takes one item per transfer: tuser selects a table load,
// an arc check or a finish, and tdata carries the arc. A load writes the next
// table entry, or gives a table-full result when the table holds TABLE_DEPTH
// entries. A check runs a lower-bound binary search over the table; each probe
// is a RAM read and then a compare. A finish sweeps the table entry by entry
// (a RAM read, then a look at the entry and its match mark), emits each
// unmatched arc with tlast on the final one (or a single done result), and
// then clears the table and both counters. One item is processed at a time;
// a new item is taken as soon as the previous one has written its table entry
// or placed its last result in the output register. A stalled master side
// holds the output register and stops the controller only when it has a
// further result to place. Reset empties the table and clears the counters,
// the pending sweep result and the output valid flag; the match mark of each
// entry is cleared when that entry is loaded.
// ----------------------------------------------------------------------------
module arc_set_compare #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // src_vertex [31:0], dst_vertex [63:32]
    input  logic [1:0]   s_tuser,   // func [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_src [31:0], out_dst [63:32],
                                    // mismatch_total [95:64], duplicate_total [127:96]
    output logic [2:0]   m_tuser,   // kind [2:0]
    output logic         m_tlast
);

    import asc_pkg::*;

    asc_cmd_t            cmd;
    asc_stat_t           stat;
    kind_t               m_kind;
    logic [VERTEX_W-1:0] m_src;
    logic [VERTEX_W-1:0] m_dst;
    logic [VERTEX_W-1:0] m_mis;
    logic [VERTEX_W-1:0] m_dup;

    asc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_func  (s_tuser),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    asc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_src   (s_tdata[31:0]),
        .s_dst   (s_tdata[63:32]),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_kind  (m_kind),
        .m_src   (m_src),
        .m_dst   (m_dst),
        .m_mis   (m_mis),
        .m_dup   (m_dup),
        .m_last  (m_tlast)
    );

    assign m_tdata = {m_dup, m_mis, m_dst, m_src};
    assign m_tuser = m_kind;

`ifndef NO_ASSERTIONS
    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT || cmd.op == OP_SW_END) |-> (!m_tvalid || m_tready))
        else $error("result written while the output register is still held");

    a_nonlast_is_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser == KIND_UNMATCHED_TABLE))
        else $error("only sweep results may be sent without tlast");

    a_done_has_no_arc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DONE) |-> (m_tdata[63:0] == '0 && m_tlast))
        else $error("done result must carry a zero arc and tlast");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the arc set comparator. A short table of directed
// transfers covers the key extremes, every input code, an empty table, repeat
// and missed checks, and sweeps with and without open entries. Random sets
// then follow: sorted tables loaded with random arcs, one completely filled
// table with overflow loads, checks that mostly hit loaded arcs, and a few
// unsorted or repeated tables. Every result is compared with an in-bench
// prediction of the comparator.
// ----------------------------------------------------------------------------
module tb;
    import asc_pkg::*;

    localparam int          DEPTH       = 64;
    localparam int          RANDOM_ITEMS = 245;
    localparam int          QUIET_FROM  = 205;
    localparam int          LONG_HOLD   = 200;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [1:0]  FN_UNUSED   = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] mis;
        logic [31:0] dup;
        logic        last;
    } outcome_t;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] src;
        logic [31:0] dst;
        bit          typed;
        kind_t       kind;
        logic [31:0] mis;
        logic [31:0] dup;
    } arc_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    logic [63:0]  tbl_keys [DEPTH];
    bit           tbl_marks [DEPTH];
    int unsigned  tbl_count;
    logic [31:0]  mis_total;
    logic [31:0]  dup_total;

    outcome_t     awaited_outcomes [$];
    int           mismatch_errors = 0;
    int           items_sent;
    int           idle_cycles = 0;
    bit           stall_on;
    int           hold_requests = 0;
    bit           pin_next;
    outcome_t     pinned_outcome;

    arc_row_t directed_rows [0:21] = '{
        '{FN_CHECK,  32'h1,        32'h2,        1'b1, KIND_UNMATCHED_STREAM, 32'd1, 32'd0},
        '{FN_FINISH, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, KIND_DONE,             32'd1, 32'd0},
        '{FN_LOAD,   32'h0,        32'h0,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_LOAD,   32'h0,        32'hFFFFFFFF, 1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_LOAD,   32'hFFFFFFFF, 32'h0,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_LOAD,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'h0,        32'h0,        1'b1, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'h0,        32'h0,        1'b1, KIND_DUPLICATE,        32'd0, 32'd1},
        '{FN_CHECK,  32'h7FFFFFFF, 32'h80000000, 1'b1, KIND_UNMATCHED_STREAM, 32'd1, 32'd1},
        '{FN_UNUSED, 32'hAAAAAAAA, 32'h55555555, 1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'h0,        32'hFFFFFFFF, 1'b1, KIND_MATCHED,          32'd1, 32'd1},
        '{FN_FINISH, 32'hFFFFFFFF, 32'h0,        1'b1, KIND_UNMATCHED_TABLE,  32'd2, 32'd1},
        '{FN_FINISH, 32'h12345678, 32'h9ABCDEF0, 1'b1, KIND_DONE,             32'd0, 32'd0},
        '{FN_LOAD,   32'h5,        32'h5,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_LOAD,   32'h3,        32'h3,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'h3,        32'h3,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'h5,        32'h5,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_CHECK,  32'h4,        32'h0,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_FINISH, 32'h0,        32'h0,        1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_LOAD,   32'h55555555, 32'hAAAAAAAA, 1'b0, KIND_MATCHED,          32'd0, 32'd0},
        '{FN_FINISH, 32'h55555555, 32'hAAAAAAAA, 1'b1, KIND_UNMATCHED_TABLE,  32'd1, 32'd0}
    };

    arc_set_compare #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned search_slot(input int unsigned n, input logic [63:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_keys[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (tbl_keys[lo] < key) begin
            lo = n;
        end
        return lo;
    endfunction

    function automatic logic [63:0] draw_key();
        case ($urandom_range(0, 3))
            0: return {$urandom(), $urandom()};
            1: return {32'($urandom_range(0, 3)), $urandom()};
            2: return {$urandom(), 32'($urandom_range(0, 3))};
            default: return {32'($urandom_range(0, 7)), 32'($urandom_range(0, 7))};
        endcase
    endfunction

    task automatic post_outcome(input kind_t kind, input logic [63:0] key, input logic last);
        outcome_t o;
        o.kind = kind;
        o.src  = key[63:32];
        o.dst  = key[31:0];
        o.mis  = mis_total;
        o.dup  = dup_total;
        o.last = last;
        awaited_outcomes.push_back(o);
    endtask

    task automatic compute_arc_outcomes(input logic [1:0] func, input logic [31:0] src,
                                        input logic [31:0] dst);
        logic [63:0] key;
        int unsigned n;
        int unsigned pos;
        int unsigned last_open;
        bit          any_open;
        key = {src, dst};
        n = tbl_count;
        any_open = 1'b0;
        last_open = 0;
        case (func)
            FN_LOAD: begin
                if (n >= DEPTH) begin
                    post_outcome(KIND_TABLE_FULL, key, 1'b1);
                end else begin
                    tbl_keys[n] = key;
                    tbl_marks[n] = 1'b0;
                    tbl_count = n + 1;
                end
            end
            FN_CHECK: begin
                pos = (n == 0) ? 0 : search_slot(n, key);
                if (n == 0 || pos >= n || tbl_keys[pos] != key) begin
                    mis_total = sat_bump(mis_total);
                    post_outcome(KIND_UNMATCHED_STREAM, key, 1'b1);
                end else if (tbl_marks[pos]) begin
                    dup_total = sat_bump(dup_total);
                    post_outcome(KIND_DUPLICATE, key, 1'b1);
                end else begin
                    tbl_marks[pos] = 1'b1;
                    post_outcome(KIND_MATCHED, key, 1'b1);
                end
            end
            FN_FINISH: begin
                for (int unsigned i = 0; i < n; i++) begin
                    if (!tbl_marks[i]) begin
                        any_open = 1'b1;
                        last_open = i;
                    end
                end
                if (!any_open) begin
                    post_outcome(KIND_DONE, 64'd0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < n; i++) begin
                        if (!tbl_marks[i]) begin
                            mis_total = sat_bump(mis_total);
                            post_outcome(KIND_UNMATCHED_TABLE, tbl_keys[i], i == last_open);
                        end
                    end
                end
                tbl_count = 0;
                mis_total = '0;
                dup_total = '0;
                foreach (tbl_marks[i]) tbl_marks[i] = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic send_arc(input logic [1:0] func, input logic [31:0] src,
                            input logic [31:0] dst);
        if (stall_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {dst, src};
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        compute_arc_outcomes(func, src, dst);
        if (pin_next) begin
            void'(awaited_outcomes.pop_back());
            awaited_outcomes.push_back(pinned_outcome);
        end
        if (func != FN_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic run_arc_set(input bit fill_all);
        logic [63:0] keys [$];
        logic [63:0] k;
        int          n;
        int          n_checks;
        int          pick;
        int          idx;
        bit          seen;
        if (fill_all) begin
            n = DEPTH;
        end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(0, 2);
        end else begin
            n = $urandom_range(3, 14);
        end
        while (keys.size() < n) begin
            k = draw_key();
            seen = 1'b0;
            foreach (keys[i]) if (keys[i] == k) seen = 1'b1;
            if (!seen) keys.push_back(k);
        end
        keys.sort();
        if (!fill_all) begin
            if ($urandom_range(0, 7) == 0) keys.shuffle();
            if (n > 0 && $urandom_range(0, 9) == 0) begin
                idx = $urandom_range(0, n - 1);
                keys.insert(idx, keys[idx]);
            end
        end
        foreach (keys[i]) send_arc(FN_LOAD, keys[i][63:32], keys[i][31:0]);
        if (fill_all) begin
            repeat (2) begin
                k = draw_key();
                send_arc(FN_LOAD, k[63:32], k[31:0]);
            end
            hold_requests++;
        end
        n_checks = fill_all ? $urandom_range(20, 30) : $urandom_range(1, 2 * n + 2);
        repeat (n_checks) begin
            pick = $urandom_range(0, 19);
            if (keys.size() > 0 && pick < 15) begin
                k = keys[$urandom_range(0, keys.size() - 1)];
                if (pick >= 12) k = pick[0] ? k + 64'd1 : k - 64'd1;
            end else begin
                k = draw_key();
            end
            send_arc((pick == 19) ? FN_UNUSED : FN_CHECK, k[63:32], k[31:0]);
        end
        k = draw_key();
        send_arc(FN_FINISH, k[63:32], k[31:0]);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_errors++;
        $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_outcomes.size() == 0) begin
                flag_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = awaited_outcomes.pop_front();
                if (m_tuser !== want.kind) flag_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[31:0] !== want.src) flag_mismatch("out_src", m_tdata[31:0], want.src);
                if (m_tdata[63:32] !== want.dst) flag_mismatch("out_dst", m_tdata[63:32], want.dst);
                if (m_tdata[95:64] !== want.mis) begin
                    flag_mismatch("mismatch_total", m_tdata[95:64], want.mis);
                end
                if (m_tdata[127:96] !== want.dup) begin
                    flag_mismatch("duplicate_total", m_tdata[127:96], want.dup);
                end
                if (m_tlast !== want.last) flag_mismatch("tlast", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int holds_done;
        holds_done = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (holds_done != hold_requests) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        int set_index;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        items_sent = 0;
        stall_on = 1'b1;
        pin_next = 1'b0;
        tbl_count = 0;
        mis_total = '0;
        dup_total = '0;
        foreach (tbl_marks[i]) tbl_marks[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            pin_next = directed_rows[r].typed;
            pinned_outcome.kind = directed_rows[r].kind;
            pinned_outcome.src  = (directed_rows[r].kind == KIND_DONE) ? 32'h0 : directed_rows[r].src;
            pinned_outcome.dst  = (directed_rows[r].kind == KIND_DONE) ? 32'h0 : directed_rows[r].dst;
            pinned_outcome.mis  = directed_rows[r].mis;
            pinned_outcome.dup  = directed_rows[r].dup;
            pinned_outcome.last = 1'b1;
            send_arc(directed_rows[r].func, directed_rows[r].src, directed_rows[r].dst);
        end
        pin_next = 1'b0;

        items_sent = 0;
        set_index = 0;
        while (items_sent < RANDOM_ITEMS) begin
            stall_on = (items_sent < QUIET_FROM) ? ($urandom_range(0, 4) != 0) : 1'b0;
            run_arc_set(set_index == 1);
            set_index++;
        end
        s_tvalid <= 1'b0;

        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
